// ----- design/cwb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Beamformer package
// Shared types, default sizes and the index helper of the weighted-sum beamformer.
// ----------------------------------------------------------------------------
package cwb_pkg;

  localparam int unsigned MAX_ANTENNAS_DEF = 32;
  localparam int unsigned MAX_BEAMS_DEF    = 32;
  localparam int unsigned MAX_CHANNELS_DEF = 8;
  localparam int unsigned RESULT_CAP       = 32;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned ACC_W   = 38;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned WGT_W   = 2 * SMP_W;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 88;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_NUM_ANTENNAS = 1'b0,
    REG_NUM_BEAMS    = 1'b1
  } cfg_reg_e;

  // Remainder of a 5-bit index by a constant count, by compares against multiples.
  function automatic logic [4:0] wrap_idx(input logic [4:0] v, input int unsigned n);
    logic [4:0] r;
    r = v;
    for (int unsigned q = 1; q < 32; q++) begin
      if (32'(v) >= q * n) begin
        r = 5'(32'(v) - q * n);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/complex_weighted_beamformer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Complex weighted-sum beamformer
// Load transactions fill the weight memory; sample transactions are multiplied
// by each beam's weight and summed per beam until the last antenna of a run.
// ----------------------------------------------------------------------------
// A load transaction and a sample for an antenna beyond the configured count
// leave the block ready for the next transaction. For a sample transaction,
// one beam per cycle while the output is not stalled is read from the weight
// memory and the accumulator memory, multiplied, added and written back
// through a four-stage pipeline; the next transaction is taken once it has
// drained. On the last antenna the beam sums leave one per cycle, lowest beam
// first, and output backpressure holds the whole pipeline. Weights must be
// loaded before they are used; the accumulators start at zero after reset.
module complex_weighted_beamformer_top #(
  parameter int unsigned MAX_ANTENNAS = cwb_pkg::MAX_ANTENNAS_DEF,
  parameter int unsigned MAX_BEAMS    = cwb_pkg::MAX_BEAMS_DEF,
  parameter int unsigned MAX_CHANNELS = cwb_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [cwb_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // channel, beam_select, antenna, value_real, value_imag, zero pad
  input  wire logic [cwb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // beam, out_channel, sum_real, sum_imag, zero pad
  output logic [cwb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // last_beam
  output logic                                 m_axis_tlast
);

  localparam int unsigned BEAM_CAP = (MAX_BEAMS < cwb_pkg::RESULT_CAP) ? MAX_BEAMS
                                                                       : cwb_pkg::RESULT_CAP;
  localparam int unsigned BCW      = (BEAM_CAP > 1) ? $clog2(BEAM_CAP) : 1;
  localparam int unsigned W_DEPTH  = MAX_CHANNELS * MAX_BEAMS * MAX_ANTENNAS;
  localparam int unsigned WAW      = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int unsigned ACC_W    = cwb_pkg::ACC_W;

  function automatic logic [WAW-1:0] w_addr(input logic [2:0] ch, input logic [4:0] bm,
                                            input logic [4:0] am);
    return WAW'((32'(cwb_pkg::wrap_idx({2'b00, ch}, MAX_CHANNELS)) * MAX_BEAMS
                 + 32'(cwb_pkg::wrap_idx(bm, MAX_BEAMS))) * MAX_ANTENNAS
                + 32'(cwb_pkg::wrap_idx(am, MAX_ANTENNAS)));
  endfunction

  // Input fields.
  logic [2:0]         in_ch;
  logic [4:0]         in_bsel;
  logic [4:0]         in_ant;
  logic [31:0]        in_val;
  cwb_pkg::opcode_e   in_op;
  logic               in_acc;

  assign in_ch   = s_axis_tdata[2:0];
  assign in_bsel = s_axis_tdata[7:3];
  assign in_ant  = s_axis_tdata[12:8];
  assign in_val  = {s_axis_tdata[28:13], s_axis_tdata[44:29]};
  assign in_op   = cwb_pkg::opcode_e'(s_axis_tuser);
  assign in_acc  = s_axis_tvalid & s_axis_tready;

  // Configuration and its clamped values.
  logic [5:0] num_ant_q, num_ant_d, num_beam_q, num_beam_d;
  logic [5:0] na_eff, nb_eff;

  always_comb begin
    if (num_ant_q == 6'd0) begin
      na_eff = 6'd1;
    end else if (32'(num_ant_q) > MAX_ANTENNAS) begin
      na_eff = 6'(MAX_ANTENNAS);
    end else begin
      na_eff = num_ant_q;
    end
    if (num_beam_q == 6'd0) begin
      nb_eff = 6'd1;
    end else if (32'(num_beam_q) > BEAM_CAP) begin
      nb_eff = 6'(BEAM_CAP);
    end else begin
      nb_eff = num_beam_q;
    end
  end

  // Pipeline control.
  logic           s0_act_q, s0_act_d;
  logic [BCW-1:0] b_q, b_d;
  logic           v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic           out_vld_q, out_vld_d;
  logic [BEAM_CAP-1:0] acc_vld_q, acc_vld_d;
  logic           en, busy, s0_fin;

  // Item and stage payload.
  logic [2:0]          item_ch_q;
  logic [4:0]          item_ant_q;
  logic signed [15:0]  item_sr_q, item_si_q;
  logic [5:0]          item_nb_q;
  logic                item_emit_q;
  logic [BCW-1:0]      b1_q, b2_q, b3_q;
  logic                fin1_q, fin2_q, fin3_q;
  logic signed [31:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [ACC_W-1:0]    acc2r_q, acc2i_q, acc3r_q, acc3i_q;
  logic signed [32:0]  pr3_q, pi3_q;
  logic [ACC_W-1:0]    new_r, new_i;
  logic [cwb_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                out_last_q;

  // Memory ports.
  logic [cwb_pkg::WGT_W-1:0] w_rdata;
  logic [2*ACC_W-1:0]        a_rdata;
  logic                      w_we, rd_en, a_we;
  logic signed [15:0]        wr1, wi1;
  logic [ACC_W-1:0]          acc1r, acc1i;

  assign en     = !out_vld_q || m_axis_tready;
  assign busy   = s0_act_q || v1_q || v2_q || v3_q;
  assign s_axis_tready = !busy;
  assign s0_fin = (6'(b_q) == item_nb_q - 6'd1);
  assign w_we   = in_acc && (in_op == cwb_pkg::OP_LOAD);
  assign rd_en  = en && s0_act_q;
  assign a_we   = en && v3_q && !item_emit_q;

  cwb_ram #(
    .WIDTH (cwb_pkg::WGT_W),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_addr(in_ch, in_bsel, in_ant)),
    .wdata_i (in_val),
    .re_i    (rd_en),
    .raddr_i (w_addr(item_ch_q, 5'(b_q), item_ant_q)),
    .rdata_o (w_rdata)
  );

  cwb_ram #(
    .WIDTH (2 * ACC_W),
    .DEPTH (BEAM_CAP)
  ) u_accum_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (b3_q),
    .wdata_i ({new_r, new_i}),
    .re_i    (rd_en),
    .raddr_i (b_q),
    .rdata_o (a_rdata)
  );

  assign wr1   = signed'(w_rdata[31:16]);
  assign wi1   = signed'(w_rdata[15:0]);
  assign acc1r = acc_vld_q[b1_q] ? a_rdata[2*ACC_W-1:ACC_W] : '0;
  assign acc1i = acc_vld_q[b1_q] ? a_rdata[ACC_W-1:0] : '0;
  assign new_r = acc3r_q + ACC_W'(pr3_q);
  assign new_i = acc3i_q + ACC_W'(pi3_q);

  always_comb begin
    num_ant_d  = num_ant_q;
    num_beam_d = num_beam_q;
    s0_act_d   = s0_act_q;
    b_d        = b_q;
    v1_d       = v1_q;
    v2_d       = v2_q;
    v3_d       = v3_q;
    out_vld_d  = out_vld_q;
    acc_vld_d  = acc_vld_q;
    if (cfg_we_i) begin
      case (cwb_pkg::cfg_reg_e'(cfg_idx_i))
        cwb_pkg::REG_NUM_ANTENNAS: num_ant_d  = cfg_data_i;
        cwb_pkg::REG_NUM_BEAMS:    num_beam_d = cfg_data_i;
        default: ;
      endcase
    end
    if (in_acc && (in_op == cwb_pkg::OP_SAMPLE) && ({1'b0, in_ant} < na_eff)) begin
      s0_act_d = 1'b1;
      b_d      = '0;
    end
    if (en) begin
      v1_d = s0_act_q;
      v2_d = v1_q;
      v3_d = v2_q;
      if (s0_act_q) begin
        if (s0_fin) begin
          s0_act_d = 1'b0;
        end else begin
          b_d = b_q + BCW'(1);
        end
      end
      if (v3_q && item_emit_q) begin
        out_vld_d = 1'b1;
        if (fin3_q) begin
          acc_vld_d = '0;
        end
      end else begin
        out_vld_d = 1'b0;
      end
      if (a_we) begin
        acc_vld_d[b3_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ant_q  <= 6'd32;
      num_beam_q <= 6'd32;
      s0_act_q   <= 1'b0;
      b_q        <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      out_vld_q  <= 1'b0;
      acc_vld_q  <= '0;
    end else begin
      num_ant_q  <= num_ant_d;
      num_beam_q <= num_beam_d;
      s0_act_q   <= s0_act_d;
      b_q        <= b_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      v3_q       <= v3_d;
      out_vld_q  <= out_vld_d;
      acc_vld_q  <= acc_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_ch_q   <= in_ch;
      item_ant_q  <= in_ant;
      item_sr_q   <= signed'(in_val[31:16]);
      item_si_q   <= signed'(in_val[15:0]);
      item_nb_q   <= nb_eff;
      item_emit_q <= ({1'b0, in_ant} == na_eff - 6'd1);
    end
    if (en) begin
      b1_q    <= b_q;
      fin1_q  <= s0_fin;
      b2_q    <= b1_q;
      fin2_q  <= fin1_q;
      p_rr_q  <= item_sr_q * wr1;
      p_ii_q  <= item_si_q * wi1;
      p_ri_q  <= item_sr_q * wi1;
      p_ir_q  <= item_si_q * wr1;
      acc2r_q <= acc1r;
      acc2i_q <= acc1i;
      b3_q    <= b2_q;
      fin3_q  <= fin2_q;
      pr3_q   <= 33'(p_rr_q) - 33'(p_ii_q);
      pi3_q   <= 33'(p_ri_q) + 33'(p_ir_q);
      acc3r_q <= acc2r_q;
      acc3i_q <= acc2i_q;
      if (v3_q && item_emit_q) begin
        out_data_q <= {4'b0000, new_i, new_r, item_ch_q, 5'(b3_q)};
        out_last_q <= fin3_q;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_beam_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_act_q |-> (6'(b_q) < item_nb_q))
    else $error("Beam counter ran past the beam count.");

  a_accum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v3_q && item_emit_q && fin3_q) |=> (acc_vld_q == '0))
    else $error("Accumulators not cleared after the final beam.");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v3_q && item_emit_q) |=> (m_axis_tvalid && (m_axis_tlast == $past(fin3_q))))
    else $error("Beam sum not presented with the right last flag.");

endmodule
`default_nettype wire

// ----- design/cwb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cwb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
